FILE: hw/rtl/msm_pkg.sv
// Shared types and constants of the mirrored stripe mapper.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package msm_pkg;

  // Default sizes, handed down from the top level
  localparam int unsigned MAX_DISKS_DEF       = 16;
  localparam int unsigned MAX_BURST_DEF       = 16;
  localparam int unsigned BLOCK_ADDR_BITS_DEF = 24;

  // Field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned START_W  = 24;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned DISK_W   = 4;
  localparam int unsigned BLOCK_W  = 24;
  localparam int unsigned STRIP_W  = 9;
  localparam int unsigned DCOUNT_W = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT   = 1'b1;

  localparam logic [STRIP_W-1:0]  STRIP_BLOCKS_RST = 9'd1;
  localparam logic [DCOUNT_W-1:0] DISK_COUNT_RST   = 5'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_FAIL    = 2'd2,
    ACT_RECOVER = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV1 = 5'b00010,
    ST_DIV2 = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch the input item
    logic div_start;   // launch the divider
    logic div_second;  // second division: strip by pair count
    logic take_off;    // keep remainder as offset within strip
    logic take_pair;   // keep remainder as pair index
    logic mul_load;    // load strip row base
    logic emit;        // load one result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_health;   // item on the input is a fail or recover
    logic in_empty;    // item on the input has a zero block count
    logic div_done;
    logic out_free;
    logic last;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msm_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both mapping divisions.
// Depends on msm_pkg for the divisor width.
`default_nettype none

module msm_divider import msm_pkg::*; #(
  parameter int unsigned DIVIDEND_W = BLOCK_ADDR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [STRIP_W-1:0]    divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quot_o,
  output logic [STRIP_W-1:0]         rem_o
);

  localparam int unsigned CNTW = $clog2(DIVIDEND_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quot_q, quot_d;
  logic [STRIP_W-1:0]    rem_q, rem_d;
  logic [STRIP_W-1:0]    dsr_q, dsr_d;
  logic [STRIP_W:0]      trial;
  logic                  fits;

  assign trial = {rem_q, quot_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? STRIP_W'(trial - {1'b0, dsr_q}) : trial[STRIP_W-1:0];
      quot_d = {quot_q[DIVIDEND_W-2:0], fits};
      cnt_d  = cnt_q + CNTW'(1);
      if (cnt_q == CNTW'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: hw/rtl/msm_datapath.sv
// Datapath of the mirrored stripe mapper: configuration, health bitmap, block walk
// and output register. Depends on msm_pkg and msm_divider.
`default_nettype none

module msm_datapath import msm_pkg::*; #(
  parameter int unsigned MAX_DISKS       = MAX_DISKS_DEF,
  parameter int unsigned MAX_BURST       = MAX_BURST_DEF,
  parameter int unsigned BLOCK_ADDR_BITS = BLOCK_ADDR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [ACTION_W-1:0]   action_i,
  input  wire logic [START_W-1:0]    start_block_i,
  input  wire logic [COUNT_W-1:0]    block_count_i,
  input  wire logic [DISK_W-1:0]     disk_id_i,
  input  wire logic                  out_stall_i,
  input  wire cmd_t                  cmd_i,
  output stat_t                      stat_o,
  output logic                       out_valid_o,
  output logic [DISK_W-1:0]          primary_disk_o,
  output logic [DISK_W-1:0]          mirror_disk_o,
  output logic [BLOCK_W-1:0]         disk_block_o,
  output logic [DISK_W-1:0]          source_disk_o,
  output logic                       both_failed_o,
  output logic                       last_result_o
);

  localparam int unsigned AW    = BLOCK_ADDR_BITS;
  localparam int unsigned NPAIR = MAX_DISKS / 2;
  localparam int unsigned PW    = (NPAIR > 1) ? $clog2(NPAIR) : 1;
  localparam int unsigned HW    = $clog2(MAX_DISKS);
  localparam int unsigned CW    = $clog2(MAX_BURST + 1);
  localparam int unsigned PRW   = AW + STRIP_W;

  // Health bit index: disk id modulo MAX_DISKS by repeated subtraction
  function automatic logic [HW-1:0] disk_idx(input logic [DISK_W-1:0] id);
    logic [6:0] v;
    v = 7'(id);
    for (int k = 0; k < 8; k++) begin
      if (v >= 7'(MAX_DISKS)) v = v - 7'(MAX_DISKS);
    end
    return HW'(v);
  endfunction

  // Configuration
  logic [STRIP_W-1:0]  strip_blocks_q;
  logic [DCOUNT_W-1:0] disk_count_q;
  logic [STRIP_W-1:0]  s_eff, p_eff, half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_blocks_q <= STRIP_BLOCKS_RST;
      disk_count_q   <= DISK_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STRIP_BLOCKS: strip_blocks_q <= cfg_data_i;
        REG_DISK_COUNT:   disk_count_q   <= cfg_data_i[DCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_eff = (strip_blocks_q == '0) ? STRIP_W'(1) : strip_blocks_q;
  assign half  = STRIP_W'(disk_count_q[DCOUNT_W-1:1]);

  always_comb begin
    if (half == '0) begin
      p_eff = STRIP_W'(1);
    end else if (half > STRIP_W'(NPAIR)) begin
      p_eff = STRIP_W'(NPAIR);
    end else begin
      p_eff = half;
    end
  end

  // Health bitmap
  logic [MAX_DISKS-1:0] healthy_q, healthy_d;

  always_comb begin
    healthy_d = healthy_q;
    if (cmd_i.accept && action_i[1]) begin
      healthy_d[disk_idx(disk_id_i)] = (action_e'(action_i) == ACT_RECOVER);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      healthy_q <= '1;
    end else begin
      healthy_q <= healthy_d;
    end
  end

  // Divider
  logic [AW-1:0]      div_quot;
  logic [STRIP_W-1:0] div_rem;
  logic               div_done;

  msm_divider #(
    .DIVIDEND_W (AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_second ? div_quot : AW'(start_block_i)),
    .divisor_i  (cmd_i.div_second ? p_eff : s_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Request and walk state
  action_e            action_q;
  logic [DISK_W-1:0]  id_q;
  logic [AW-1:0]      lba_q, lba_d;
  logic [STRIP_W-1:0] off_q, off_d;
  logic [PW-1:0]      pair_q, pair_d;
  logic [AW-1:0]      base_q, base_d;
  logic [CW-1:0]      remain_q, remain_d;
  logic [CW-1:0]      count_sat;
  logic [PRW-1:0]     prod;

  assign count_sat = (8'(block_count_i) > 8'(MAX_BURST)) ? CW'(MAX_BURST) : CW'(block_count_i);
  assign prod      = PRW'(div_quot) * PRW'(s_eff);

  // Result of the current position
  logic [HW-1:0]      pidx, midx, partner_idx;
  logic               hp, hm;
  logic [STRIP_W-1:0] off_inc, pair_inc;
  logic [DISK_W-1:0]  res_prim, res_mir, res_src;
  logic [BLOCK_W-1:0] res_blk;
  logic               res_both;
  logic               last;

  assign pidx        = HW'({pair_q, 1'b0});
  assign midx        = HW'({pair_q, 1'b1});
  assign partner_idx = disk_idx(id_q ^ DISK_W'(1));
  assign hp          = healthy_q[pidx];
  assign hm          = healthy_q[midx];
  assign off_inc     = off_q + STRIP_W'(1);
  assign pair_inc    = STRIP_W'(pair_q) + STRIP_W'(1);
  assign last        = (remain_q == CW'(1));

  always_comb begin
    if (action_q == ACT_FAIL || action_q == ACT_RECOVER) begin
      res_prim = {id_q[DISK_W-1:1], 1'b0};
      res_mir  = {id_q[DISK_W-1:1], 1'b1};
      res_blk  = '0;
      res_src  = id_q ^ DISK_W'(1);
      res_both = !healthy_q[partner_idx];
    end else begin
      res_prim = DISK_W'({pair_q, 1'b0});
      res_mir  = DISK_W'({pair_q, 1'b1});
      res_blk  = BLOCK_W'(base_q + AW'(off_q));
      res_src  = (action_q == ACT_READ && !hp && hm) ? res_mir : res_prim;
      res_both = !hp && !hm;
    end
  end

  always_comb begin
    lba_d    = lba_q;
    off_d    = off_q;
    pair_d   = pair_q;
    base_d   = base_q;
    remain_d = remain_q;
    if (cmd_i.accept) begin
      lba_d    = AW'(start_block_i);
      remain_d = action_i[1] ? CW'(1) : count_sat;
    end
    if (cmd_i.take_off) off_d = div_rem;
    if (cmd_i.take_pair) pair_d = PW'(div_rem);
    if (cmd_i.mul_load) base_d = prod[AW-1:0];
    if (cmd_i.emit) begin
      remain_d = remain_q - CW'(1);
      if (&lba_q) begin
        // address wraps to the first block of pair 0
        lba_d  = '0;
        off_d  = '0;
        pair_d = '0;
        base_d = '0;
      end else begin
        lba_d = lba_q + AW'(1);
        if (off_inc == s_eff) begin
          off_d = '0;
          if (pair_inc == p_eff) begin
            pair_d = '0;
            base_d = base_q + AW'(s_eff);
          end else begin
            pair_d = PW'(pair_inc);
          end
        end else begin
          off_d = off_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_e'(action_i);
      id_q     <= disk_id_i;
    end
    lba_q    <= lba_d;
    off_q    <= off_d;
    pair_q   <= pair_d;
    base_q   <= base_d;
    remain_q <= remain_d;
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      primary_disk_o <= res_prim;
      mirror_disk_o  <= res_mir;
      disk_block_o   <= res_blk;
      source_disk_o  <= res_src;
      both_failed_o  <= res_both;
      last_result_o  <= last;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.in_health = action_i[1];
  assign stat_o.in_empty  = (block_count_i == '0);
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.last      = last;

endmodule

`default_nettype wire

FILE: hw/rtl/msm_ctrl.sv
// Controller of the mirrored stripe mapper: sequences accept, two divisions,
// row base multiply and result emission. Depends on msm_pkg.
`default_nettype none

module msm_ctrl import msm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output state_e     state_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.in_health) begin
            state_d = ST_EMIT;
          end else if (!stat_i.in_empty) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV1;
          end
        end
      end
      ST_DIV1: begin
        if (stat_i.div_done) begin
          cmd_o.take_off   = 1'b1;
          cmd_o.div_start  = 1'b1;
          cmd_o.div_second = 1'b1;
          state_d          = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (stat_i.div_done) begin
          cmd_o.take_pair = 1'b1;
          state_d         = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        // hold while the output register is still full
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign state_o    = state_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mirrored_stripe_mapper_core.sv
// RAID 10 address mapper, top level: controller, datapath and checks.
// Depends on msm_pkg, msm_ctrl, msm_datapath (and msm_divider below it).
`default_nettype none

// Maps read and write requests onto mirrored disk pairs, one result per block,
// and keeps a per-disk health bitmap updated by fail and recover requests.
// One request is handled at a time. A read or write is accepted, passes twice
// through the shared one-bit-per-cycle divider, loads its row base from the
// multiply and then gives one result per cycle while the output side does not
// stall. A fail or recover goes from the accept straight to its result;
// a read or write with a zero block count is taken in the idle state and
// gives no result. The next request is accepted while the last result still
// waits in the output register. Configuration writes are always taken and
// belong only between requests.

module mirrored_stripe_mapper_core import msm_pkg::*; #(
  parameter int unsigned MAX_DISKS       = MAX_DISKS_DEF,
  parameter int unsigned MAX_BURST       = MAX_BURST_DEF,
  parameter int unsigned BLOCK_ADDR_BITS = BLOCK_ADDR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [ACTION_W-1:0]   action_i,
  input  wire logic [START_W-1:0]    start_block_i,
  input  wire logic [COUNT_W-1:0]    block_count_i,
  input  wire logic [DISK_W-1:0]     disk_id_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [DISK_W-1:0]          primary_disk_o,
  output logic [DISK_W-1:0]          mirror_disk_o,
  output logic [BLOCK_W-1:0]         disk_block_o,
  output logic [DISK_W-1:0]          source_disk_o,
  output logic                       both_failed_o,
  output logic                       last_result_o
);

  cmd_t   cmd;
  stat_t  stat;
  state_e state;

  assign cfg_ready_o = 1'b1;

  msm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  msm_datapath #(
    .MAX_DISKS       (MAX_DISKS),
    .MAX_BURST       (MAX_BURST),
    .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .start_block_i  (start_block_i),
    .block_count_i  (block_count_i),
    .disk_id_i      (disk_id_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .primary_disk_o (primary_disk_o),
    .mirror_disk_o  (mirror_disk_o),
    .disk_block_o   (disk_block_o),
    .source_disk_o  (source_disk_o),
    .both_failed_o  (both_failed_o),
    .last_result_o  (last_result_o)
  );

  // A result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stat.out_free)
    else $error("result loaded into a full output register");

  // A divider completion only arrives while the controller waits for one
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> (state == ST_DIV1 || state == ST_DIV2))
    else $error("divider finished outside a division state");

  // A request that yields results keeps the input side stalled afterwards
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (action_i[1] || block_count_i != '0)) |=> in_stall_o)
    else $error("input taken again before request finished");

endmodule

`default_nettype wire

FILE: bench/mirrored_stripe_mapper_core_test.sv
// Self-checking bench for mirrored_stripe_mapper_core: RAID 10 block mapping and disk health.
// Depends on msm_pkg and the core; a built-in mapper model predicts every result transfer.
`timescale 1ns / 1ps

module mirrored_stripe_mapper_core_test;
  import msm_pkg::*;

  localparam int unsigned QUIET_CYCLES = 2 * BLOCK_ADDR_BITS_DEF + 4 + MAX_BURST_DEF + 12;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 46;

  typedef struct {
    action_e            act;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
    logic [DISK_W-1:0]  disk;
  } disk_request_t;

  typedef struct {
    logic [DISK_W-1:0]  primary;
    logic [DISK_W-1:0]  mirror;
    logic [BLOCK_W-1:0] blk;
    logic [DISK_W-1:0]  source;
    logic               both;
    logic               last;
  } map_result_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_STRIP_BLOCKS;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [ACTION_W-1:0]   action_i      = ACT_READ;
  logic [START_W-1:0]    start_block_i = '0;
  logic [COUNT_W-1:0]    block_count_i = '0;
  logic [DISK_W-1:0]     disk_id_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [DISK_W-1:0]     primary_disk_o;
  logic [DISK_W-1:0]     mirror_disk_o;
  logic [BLOCK_W-1:0]    disk_block_o;
  logic [DISK_W-1:0]     source_disk_o;
  logic                  both_failed_o;
  logic                  last_result_o;

  mirrored_stripe_mapper_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .start_block_i  (start_block_i),
    .block_count_i  (block_count_i),
    .disk_id_i      (disk_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .primary_disk_o (primary_disk_o),
    .mirror_disk_o  (mirror_disk_o),
    .disk_block_o   (disk_block_o),
    .source_disk_o  (source_disk_o),
    .both_failed_o  (both_failed_o),
    .last_result_o  (last_result_o)
  );

  // Mapper state as the bench sees it
  logic [STRIP_W-1:0]  strip_cfg  = STRIP_BLOCKS_RST;
  logic [DCOUNT_W-1:0] dcount_cfg = DISK_COUNT_RST;
  logic                disk_ok [MAX_DISKS_DEF];

  disk_request_t request_q[$];
  map_result_t   expected_maps[$];
  int unsigned   mismatches    = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct     = 0;
  int unsigned   hold_req      = 0;
  int unsigned   hold_seen     = 0;
  int unsigned   hold_left     = 0;

  function automatic int unsigned pair_total();
    int unsigned p;
    p = dcount_cfg / 2;
    if (p < 1) p = 1;
    if (p > MAX_DISKS_DEF / 2) p = MAX_DISKS_DEF / 2;
    return p;
  endfunction

  // Work out every result transfer that one accepted request causes
  function automatic void map_request(input disk_request_t r);
    logic [DISK_W-1:0]  partner;
    logic [BLOCK_W-1:0] lba;
    int unsigned        s;
    int unsigned        p;
    int unsigned        n;
    int unsigned        strip_no;
    int unsigned        pair;
    map_result_t        res;
    if (r.act == ACT_FAIL || r.act == ACT_RECOVER) begin
      partner = r.disk ^ 4'd1;
      disk_ok[r.disk] = (r.act == ACT_RECOVER);
      res.primary = {r.disk[DISK_W-1:1], 1'b0};
      res.mirror  = {r.disk[DISK_W-1:1], 1'b1};
      res.blk     = '0;
      res.source  = partner;
      res.both    = !disk_ok[partner];
      res.last    = 1'b1;
      expected_maps.push_back(res);
    end else begin
      s = (strip_cfg == 0) ? 1 : strip_cfg;
      p = pair_total();
      n = (r.count > MAX_BURST_DEF) ? MAX_BURST_DEF : r.count;
      for (int unsigned i = 0; i < n; i++) begin
        lba         = r.start + BLOCK_W'(i);
        strip_no    = lba / s;
        pair        = strip_no % p;
        res.primary = DISK_W'(pair * 2);
        res.mirror  = DISK_W'(pair * 2 + 1);
        res.blk     = BLOCK_W'((strip_no / p) * s + lba % s);
        res.both    = !disk_ok[res.primary] && !disk_ok[res.mirror];
        res.source  = res.primary;
        if (r.act == ACT_READ && !disk_ok[res.primary] && disk_ok[res.mirror])
          res.source = res.mirror;
        res.last    = (i + 1 == n);
        expected_maps.push_back(res);
      end
    end
  endfunction

  function automatic void queue_request(action_e act, int unsigned start, int unsigned count,
                                        int unsigned disk);
    disk_request_t r;
    r.act   = act;
    r.start = START_W'(start);
    r.count = COUNT_W'(count);
    r.disk  = DISK_W'(disk);
    request_q.push_back(r);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Registers are written only with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_STRIP_BLOCKS) strip_cfg = val[STRIP_W-1:0];
    else dcount_cfg = val[DCOUNT_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    while (request_q.size() != 0 || in_valid_i || expected_maps.size() != 0)
      @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("mirrored_stripe_mapper_core: mismatch");
    $finish;
  end

  // Request driver: hold the payload while stalled, advance after each transfer
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    disk_request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        req.act   = action_e'(action_i);
        req.start = start_block_i;
        req.count = block_count_i;
        req.disk  = disk_id_i;
        map_request(req);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = request_q.pop_front();
          in_valid_i    <= 1'b1;
          action_i      <= req.act;
          start_block_i <= req.start;
          block_count_i <= req.count;
          disk_id_i     <= req.disk;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure, with an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen   <= hold_req;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    map_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_maps.size() == 0) begin
        $error("unexpected result transfer: disk %0d block %0d", primary_disk_o, disk_block_o);
        mismatches++;
      end else begin
        want = expected_maps.pop_front();
        check_field("primary_disk", want.primary, primary_disk_o);
        check_field("mirror_disk", want.mirror, mirror_disk_o);
        check_field("disk_block", want.blk, disk_block_o);
        check_field("source_disk", want.source, source_disk_o);
        check_field("both_failed", want.both, both_failed_o);
        check_field("last_result", want.last, last_result_o);
      end
    end
  end

  initial begin : run_phases
    int unsigned strip_set [RAND_PHASES];
    int unsigned dcount_set [RAND_PHASES];
    int unsigned pick;
    int unsigned start;
    int unsigned count;
    int unsigned disk;
    strip_set  = '{1, 0, 511, 256, 3, 8, 0, 2};
    dcount_set = '{2, 0, 31, 16, 7, 8, 0, 1};
    for (int i = 0; i < MAX_DISKS_DEF; i++) disk_ok[i] = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: four pairs, strips of four blocks
    write_reg(REG_STRIP_BLOCKS, 9'd4);
    write_reg(REG_DISK_COUNT, {4'hF, 5'd8});
    queue_request(ACT_READ, 0, 1, 0);
    queue_request(ACT_READ, 24'hFFFFFF, 16, 15);      // address wraps to zero
    queue_request(ACT_WRITE, 24'h123456, 16, 0);
    queue_request(ACT_READ, 0, 0, 0);                  // nothing comes back
    queue_request(ACT_READ, 5, 31, 0);                 // count saturates
    queue_request(ACT_WRITE, 100, 17, 0);
    queue_request(ACT_WRITE, 7, 0, 0);
    queue_request(ACT_FAIL, 0, 1, 0);
    queue_request(ACT_READ, 0, 4, 0);                  // served from the mirror
    queue_request(ACT_WRITE, 0, 2, 0);
    queue_request(ACT_FAIL, 0, 1, 1);                  // pair lost
    queue_request(ACT_READ, 2, 3, 0);
    queue_request(ACT_WRITE, 3, 1, 0);
    queue_request(ACT_RECOVER, 0, 1, 0);               // partner still down
    queue_request(ACT_READ, 0, 2, 0);
    queue_request(ACT_RECOVER, 0, 1, 1);
    queue_request(ACT_FAIL, 0, 1, 15);
    queue_request(ACT_FAIL, 0, 1, 14);
    queue_request(ACT_RECOVER, 0, 1, 15);
    queue_request(ACT_RECOVER, 0, 1, 14);
    queue_request(ACT_FAIL, 0, 1, 9);
    queue_request(ACT_READ, 24'h7FFFF0, 16, 9);
    queue_request(ACT_RECOVER, 0, 1, 9);
    queue_request(ACT_READ, 24'hFFFFFF, 1, 0);
    drain_all();

    dcount_set[6] = 2 * $urandom_range(1, 8);
    strip_set[6]  = $urandom_range(1, 40);
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_STRIP_BLOCKS, CFG_DATA_W'(strip_set[ph]));
      write_reg(REG_DISK_COUNT, {4'($urandom), DCOUNT_W'(dcount_set[ph])});
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      // Hold the result side off while the sender keeps offering
      if (ph == 4) hold_req++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick  = $urandom_range(99);
        start = ($urandom_range(7) == 0) ? 24'hFFFFFF - $urandom_range(20) : $urandom;
        count = $urandom_range(9);
        if (count == 0) count = 0;
        else if (count == 1) count = $urandom_range(17, 31);
        else count = $urandom_range(1, 16);
        disk  = ($urandom_range(3) != 0) ? $urandom_range(2 * pair_total() - 1)
                                         : $urandom_range(15);
        if (pick < 40) queue_request(ACT_READ, start, count, disk);
        else if (pick < 70) queue_request(ACT_WRITE, start, count, disk);
        else if (pick < 85) queue_request(ACT_FAIL, start, count, disk);
        else queue_request(ACT_RECOVER, start, count, disk);
      end
      drain_all();
    end

    if (mismatches == 0) begin
      $display("mirrored_stripe_mapper_core: match");
    end else begin
      $display("mirrored_stripe_mapper_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: mirrored_stripe_mapper_core.f
hw/rtl/msm_pkg.sv
hw/rtl/msm_divider.sv
hw/rtl/msm_datapath.sv
hw/rtl/msm_ctrl.sv
hw/rtl/mirrored_stripe_mapper_core.sv
bench/mirrored_stripe_mapper_core_test.sv
